FILE: sv/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types, constants and helpers of the flame point transform.
// ----------------------------------------------------------------------------
package fpt_pkg;

    localparam int CFG_W   = 48;
    localparam int COEF_W  = 16;
    localparam int COEF_FB = 12;      // Q4.12 fraction bits
    localparam int IDX_W   = 3;
    localparam int KINDS_W = 6;
    localparam int MAX_SLOTS = 3;

    localparam logic signed [31:0] INV_TWO_PI = 32'sd683565276;
    localparam logic signed [15:0] SIN_A = 16'sd25736;
    localparam logic signed [15:0] SIN_B = -16'sd10512;
    localparam logic [10:0]        SIN_C = 11'd1160;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    localparam logic [CFG_W-1:0] COEF_X_ONE = 48'h0000_0000_1000;
    localparam logic [CFG_W-1:0] COEF_Y_ONE = 48'h0000_1000_0000;

    typedef enum logic [IDX_W-1:0] {
        REG_PRE_X   = 3'd0,
        REG_PRE_Y   = 3'd1,
        REG_POST_X  = 3'd2,
        REG_POST_Y  = 3'd3,
        REG_WEIGHTS = 3'd4,
        REG_KINDS   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_ID  = 2'd0,
        KIND_SIN = 2'd1,
        KIND_SPH = 2'd2,
        KIND_OFF = 2'd3
    } kind_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } sat_t;

    // one restoring-divide step travels as this word between cells
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] d;
        logic [33:0] q;
        logic [31:0] num;
        logic        neg;
    } div_t;

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > SAT_MAX)
        begin
            r.val = SAT_MAX[31:0];
            r.ovf = 1'b1;
        end
        else if (v < SAT_MIN)
        begin
            r.val = SAT_MIN[31:0];
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = v[31:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: sv/fpt_affine.sv
// ----------------------------------------------------------------------------
// fpt_affine
// One affine row: a*x + b*y + offset, two stages, saturated to 32 bits.
// ----------------------------------------------------------------------------
module fpt_affine #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic [fpt_pkg::CFG_W-1:0]  coeffs,
    input  logic signed [31:0]         x,
    input  logic signed [31:0]         y,
    output logic signed [31:0]         res,
    output logic                       ovf
);
    import fpt_pkg::*;

    localparam int OFF_L = (FRAC_BITS >= COEF_FB) ? FRAC_BITS - COEF_FB : 0;
    localparam int OFF_R = (FRAC_BITS < COEF_FB) ? COEF_FB - FRAC_BITS : 0;

    logic signed [COEF_W-1:0] a, b, o;
    logic signed [47:0] pa_reg, pb_reg;
    logic signed [49:0] sum, off, tot;
    sat_t sat_next;

    assign a = coeffs[15:0];
    assign b = coeffs[31:16];
    assign o = coeffs[47:32];

    always_ff @(posedge clk)
    begin
        pa_reg <= a * x;
        pb_reg <= b * y;
    end

    always_comb
    begin
        sum      = 50'(pa_reg) + 50'(pb_reg);
        off      = (50'(o) <<< OFF_L) >>> OFF_R;
        tot      = (sum >>> COEF_FB) + off;
        sat_next = sat32(64'(tot));
    end

    always_ff @(posedge clk)
    begin
        res <= sat_next.val;
        ovf <= sat_next.ovf;
    end

endmodule

FILE: sv/fpt_sine.sv
// ----------------------------------------------------------------------------
// fpt_sine
// Fixed-point sine: phase from turn fraction, quarter-wave polynomial, 5 stages.
// ----------------------------------------------------------------------------
module fpt_sine #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic signed [31:0] v,
    output logic signed [31:0] res
);
    import fpt_pkg::*;

    localparam int SL = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
    localparam int SR = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;

    logic signed [63:0] prod_reg;
    logic [15:0]        p;
    logic [14:0]        z;
    logic [29:0]        zz;
    logic [14:0]        z_reg2, z_reg3, z_reg4;
    logic [14:0]        z2_reg2, z2_reg3;
    logic [1:0]         quad_reg2, quad_reg3, quad_reg4;
    logic [25:0]        cz;
    logic signed [15:0] t1_reg;
    logic signed [31:0] t1z;
    logic signed [17:0] t2_reg;
    logic signed [33:0] t2z;
    logic signed [17:0] t3, t3s;
    logic signed [31:0] tw;

    always_ff @(posedge clk)
    begin
        prod_reg <= v * INV_TWO_PI;
    end

    always_comb
    begin
        p  = prod_reg[FRAC_BITS+31:FRAC_BITS+16];
        z  = p[14] ? 15'(15'd16384 - 15'(p[13:0])) : 15'(p[13:0]);
        zz = z * z;
    end

    always_ff @(posedge clk)
    begin
        z_reg2    <= z;
        z2_reg2   <= zz[28:14];
        quad_reg2 <= p[15:14];
    end

    always_comb
    begin
        cz = SIN_C * z2_reg2;
    end

    always_ff @(posedge clk)
    begin
        t1_reg    <= 16'(cz[25:14]) + SIN_B;
        z_reg3    <= z_reg2;
        z2_reg3   <= z2_reg2;
        quad_reg3 <= quad_reg2;
    end

    always_comb
    begin
        t1z = t1_reg * $signed({1'b0, z2_reg3});
    end

    always_ff @(posedge clk)
    begin
        t2_reg    <= 18'(t1z >>> 14) + 18'(SIN_A);
        z_reg4    <= z_reg3;
        quad_reg4 <= quad_reg3;
    end

    always_comb
    begin
        t2z = t2_reg * $signed({1'b0, z_reg4});
        t3  = 18'(t2z >>> 14);
        t3s = quad_reg4[1] ? -t3 : t3;
        tw  = 32'(t3s);
    end

    always_ff @(posedge clk)
    begin
        res <= (tw <<< SL) >>> SR;
    end

endmodule

FILE: sv/fpt_div_cell.sv
// ----------------------------------------------------------------------------
// fpt_div_cell
// One restoring-divide step, registered; cells chain into a pipelined divider.
// ----------------------------------------------------------------------------
module fpt_div_cell (
    input  logic          clk,
    input  fpt_pkg::div_t cin,
    output fpt_pkg::div_t cout
);
    import fpt_pkg::*;

    localparam logic [34:0] Q_CLAMP = 35'h2_0000_0000;

    logic [63:0] rem_shift, rem_next;
    logic [34:0] q_shift;
    logic [33:0] q_next;
    logic        ge;

    always_comb
    begin
        rem_shift = {cin.rem[62:0], cin.num[31]};
        ge        = rem_shift >= cin.d;
        rem_next  = ge ? rem_shift - cin.d : rem_shift;
        q_shift   = {cin.q, ge};
        q_next    = (q_shift > Q_CLAMP) ? Q_CLAMP[33:0] : q_shift[33:0];
    end

    always_ff @(posedge clk)
    begin
        cout.rem <= rem_next;
        cout.d   <= cin.d;
        cout.q   <= q_next;
        cout.num <= {cin.num[30:0], 1'b0};
        cout.neg <= cin.neg;
    end

endmodule

FILE: sv/fpt_slot.sv
// ----------------------------------------------------------------------------
// fpt_slot
// One variation slot: identity, sine, spherical or off, chosen by its kind code.
// ----------------------------------------------------------------------------
module fpt_slot #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic [1:0]         kind,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    output logic signed [31:0] sx,
    output logic signed [31:0] sy,
    output logic               flag
);
    import fpt_pkg::*;

    localparam int N_CELLS = 32 + 2 * FRAC_BITS;
    localparam int ID_DLY  = N_CELLS + 2;
    localparam int SIN_DLY = N_CELLS - 3;

    logic signed [31:0] id_x_reg [ID_DLY];
    logic signed [31:0] id_y_reg [ID_DLY];
    logic signed [31:0] sin_x, sin_y;
    logic signed [31:0] sin_x_reg [SIN_DLY];
    logic signed [31:0] sin_y_reg [SIN_DLY];

    logic signed [63:0] sqx_reg, sqy_reg;
    logic [31:0]        magx_reg, magy_reg;
    logic               negx_reg, negy_reg;
    logic [63:0]        d_reg, d_sum;
    logic [31:0]        magx_reg2, magy_reg2;
    logic               negx_reg2, negy_reg2;
    logic               zero_reg [N_CELLS + 1];

    div_t chain_x [N_CELLS + 1];
    div_t chain_y [N_CELLS + 1];

    logic signed [63:0] qx, qy;
    sat_t sph_x, sph_y;

    always_ff @(posedge clk)
    begin
        id_x_reg[0] <= px;
        id_y_reg[0] <= py;
        for (int k = 1; k < ID_DLY; k++)
        begin
            id_x_reg[k] <= id_x_reg[k-1];
            id_y_reg[k] <= id_y_reg[k-1];
        end
    end

    fpt_sine #(.FRAC_BITS(FRAC_BITS)) u_sin_x (.clk(clk), .v(px), .res(sin_x));
    fpt_sine #(.FRAC_BITS(FRAC_BITS)) u_sin_y (.clk(clk), .v(py), .res(sin_y));

    always_ff @(posedge clk)
    begin
        sin_x_reg[0] <= sin_x;
        sin_y_reg[0] <= sin_y;
        for (int k = 1; k < SIN_DLY; k++)
        begin
            sin_x_reg[k] <= sin_x_reg[k-1];
            sin_y_reg[k] <= sin_y_reg[k-1];
        end
    end

    // spherical: squares, then radius squared, then the divider chain
    always_ff @(posedge clk)
    begin
        sqx_reg  <= px * px;
        sqy_reg  <= py * py;
        magx_reg <= px[31] ? 32'(-px) : 32'(px);
        magy_reg <= py[31] ? 32'(-py) : 32'(py);
        negx_reg <= px[31];
        negy_reg <= py[31];
    end

    assign d_sum = 64'(sqx_reg) + 64'(sqy_reg);

    always_ff @(posedge clk)
    begin
        d_reg       <= d_sum;
        zero_reg[0] <= (d_sum == 64'd0);
        magx_reg2   <= magx_reg;
        magy_reg2   <= magy_reg;
        negx_reg2   <= negx_reg;
        negy_reg2   <= negy_reg;
        for (int k = 1; k <= N_CELLS; k++)
        begin
            zero_reg[k] <= zero_reg[k-1];
        end
    end

    assign chain_x[0] = '{rem: 64'd0, d: d_reg, q: 34'd0, num: magx_reg2, neg: negx_reg2};
    assign chain_y[0] = '{rem: 64'd0, d: d_reg, q: 34'd0, num: magy_reg2, neg: negy_reg2};

    for (genvar g = 0; g < N_CELLS; g++)
    begin : g_cell
        fpt_div_cell u_cx (.clk(clk), .cin(chain_x[g]), .cout(chain_x[g+1]));
        fpt_div_cell u_cy (.clk(clk), .cin(chain_y[g]), .cout(chain_y[g+1]));
    end

    always_comb
    begin
        qx    = 64'(chain_x[N_CELLS].q);
        qy    = 64'(chain_y[N_CELLS].q);
        sph_x = sat32(chain_x[N_CELLS].neg ? -qx : qx);
        sph_y = sat32(chain_y[N_CELLS].neg ? -qy : qy);
    end

    always_ff @(posedge clk)
    begin
        unique case (kind_t'(kind))
            KIND_ID:
            begin
                sx   <= id_x_reg[ID_DLY-1];
                sy   <= id_y_reg[ID_DLY-1];
                flag <= 1'b0;
            end
            KIND_SIN:
            begin
                sx   <= sin_x_reg[SIN_DLY-1];
                sy   <= sin_y_reg[SIN_DLY-1];
                flag <= 1'b0;
            end
            KIND_SPH:
            begin
                if (zero_reg[N_CELLS])
                begin
                    sx   <= 32'sd0;
                    sy   <= 32'sd0;
                    flag <= 1'b1;
                end
                else
                begin
                    sx   <= sph_x.val;
                    sy   <= sph_y.val;
                    flag <= sph_x.ovf | sph_y.ovf;
                end
            end
            KIND_OFF:
            begin
                sx   <= 32'sd0;
                sy   <= 32'sd0;
                flag <= 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/flame_point_transform.sv
// ----------------------------------------------------------------------------
// flame_point_transform
// Pre-affine, weighted variation slots, post-affine on one Q point per cycle.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+---------------------
//  point in | point_x, point_y                         | start && !busy
//  result   | out_x, out_y, range_flag                 | done, one cycle
//  config   | wr_en, wr_index, wr_data                 | wr_en
//
//  One word accepted every cycle; busy stays low.
//  Latency is set by the spherical divider chain
//  (one cell per quotient bit, 2*FRAC_BITS + 32 cells).
//  Reset clears the valid pipeline and loads the default coefficients.
//  The receiver cannot stall; each result is shown for one cycle with done.
// ----------------------------------------------------------------------------
module flame_point_transform #(
    parameter int NUM_SLOTS = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         point_x,
    input  logic signed [31:0]         point_y,
    output logic                       done,
    output logic signed [31:0]         out_x,
    output logic signed [31:0]         out_y,
    output logic                       range_flag,
    input  logic                       wr_en,
    input  logic [fpt_pkg::IDX_W-1:0]  wr_index,
    input  logic [fpt_pkg::CFG_W-1:0]  wr_data
);
    import fpt_pkg::*;

    localparam int SLOT_LAT = 2 * FRAC_BITS + 35;
    localparam int LAT      = SLOT_LAT + 6;

    logic [CFG_W-1:0]   pre_x_reg, pre_y_reg, post_x_reg, post_y_reg, weights_reg;
    logic [KINDS_W-1:0] kinds_reg;
    logic [LAT-1:0]     vld_reg;

    logic signed [31:0] px, py;
    logic               pre_ovf_x, pre_ovf_y;
    logic               pf_reg [SLOT_LAT];

    logic signed [31:0] sx [NUM_SLOTS];
    logic signed [31:0] sy [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_flag;

    logic signed [47:0] wx_reg [NUM_SLOTS];
    logic signed [47:0] wy_reg [NUM_SLOTS];
    logic               wflag_reg;

    logic signed [49:0] sum_x, sum_y;
    sat_t               acc_x, acc_y;
    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic               aflag_reg, pflag_reg1, pflag_reg2;
    logic               post_ovf_x, post_ovf_y;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_x_reg   <= COEF_X_ONE;
            pre_y_reg   <= COEF_Y_ONE;
            post_x_reg  <= COEF_X_ONE;
            post_y_reg  <= COEF_Y_ONE;
            weights_reg <= '0;
            kinds_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_PRE_X:   pre_x_reg   <= wr_data;
                REG_PRE_Y:   pre_y_reg   <= wr_data;
                REG_POST_X:  post_x_reg  <= wr_data;
                REG_POST_Y:  post_y_reg  <= wr_data;
                REG_WEIGHTS: weights_reg <= wr_data;
                REG_KINDS:   kinds_reg   <= wr_data[KINDS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
        end
    end

    fpt_affine #(.FRAC_BITS(FRAC_BITS)) u_pre_x (
        .clk(clk), .coeffs(pre_x_reg), .x(point_x), .y(point_y),
        .res(px), .ovf(pre_ovf_x)
    );
    fpt_affine #(.FRAC_BITS(FRAC_BITS)) u_pre_y (
        .clk(clk), .coeffs(pre_y_reg), .x(point_x), .y(point_y),
        .res(py), .ovf(pre_ovf_y)
    );

    always_ff @(posedge clk)
    begin
        pf_reg[0] <= pre_ovf_x | pre_ovf_y;
        for (int k = 1; k < SLOT_LAT; k++)
        begin
            pf_reg[k] <= pf_reg[k-1];
        end
    end

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_slot
        fpt_slot #(.FRAC_BITS(FRAC_BITS)) u_slot (
            .clk(clk), .kind(kinds_reg[2*i +: 2]), .px(px), .py(py),
            .sx(sx[i]), .sy(sy[i]), .flag(slot_flag[i])
        );

        always_ff @(posedge clk)
        begin
            wx_reg[i] <= $signed(weights_reg[COEF_W*i +: COEF_W]) * sx[i];
            wy_reg[i] <= $signed(weights_reg[COEF_W*i +: COEF_W]) * sy[i];
        end
    end

    always_ff @(posedge clk)
    begin
        wflag_reg <= pf_reg[SLOT_LAT-1] | (|slot_flag);
    end

    always_comb
    begin
        sum_x = '0;
        sum_y = '0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            sum_x = sum_x + 50'(wx_reg[k]);
            sum_y = sum_y + 50'(wy_reg[k]);
        end
        acc_x = sat32(64'(sum_x >>> COEF_FB));
        acc_y = sat32(64'(sum_y >>> COEF_FB));
    end

    always_ff @(posedge clk)
    begin
        acc_x_reg  <= acc_x.val;
        acc_y_reg  <= acc_y.val;
        aflag_reg  <= wflag_reg | acc_x.ovf | acc_y.ovf;
        pflag_reg1 <= aflag_reg;
        pflag_reg2 <= pflag_reg1;
    end

    fpt_affine #(.FRAC_BITS(FRAC_BITS)) u_post_x (
        .clk(clk), .coeffs(post_x_reg), .x(acc_x_reg), .y(acc_y_reg),
        .res(out_x), .ovf(post_ovf_x)
    );
    fpt_affine #(.FRAC_BITS(FRAC_BITS)) u_post_y (
        .clk(clk), .coeffs(post_y_reg), .x(acc_x_reg), .y(acc_y_reg),
        .res(out_y), .ovf(post_ovf_y)
    );

    assign range_flag = pflag_reg2 | post_ovf_x | post_ovf_y;
    assign done       = vld_reg[LAT-1];

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted word produced no result");

    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without an accepted word");

    a_flag_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[SLOT_LAT+3] && aflag_reg) |-> ##2 (done && range_flag))
        else $error("range flag lost in post stage");

endmodule

FILE: test/flame_point_transform_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flame_point_transform_tb
// Streams Q16.16 points through the transform under several coefficient,
// weight and slot-kind settings, predicts every word in the bench and checks
// each result word field by field as it leaves the block.
// ----------------------------------------------------------------------------
module flame_point_transform_tb;

    import fpt_pkg::*;

    localparam int FRAC     = 16;
    localparam int SETTLE   = 90;      // longer than the pipeline depth
    localparam int N_PHASES = 12;
    localparam int PER_PHASE = 150;
    localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd7;

    typedef enum logic [1:0] {ACT_POINT, ACT_WRITE, ACT_DRAIN} act_t;

    typedef struct {
        act_t               act;
        logic [IDX_W-1:0]   idx;
        logic [CFG_W-1:0]   data;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } job_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               flag;
    } point_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic wr_en = 1'b0;
    logic [IDX_W-1:0] wr_index = '0;
    logic [CFG_W-1:0] wr_data = '0;
    logic busy, done, range_flag;
    logic signed [31:0] out_x, out_y;

    job_t       jobs[$];
    point_res_t expected_pts[$];
    int         n_errors = 0;
    int         n_points = 0;
    int         n_writes = 0;
    int         n_flagged = 0;

    // model copy of the configuration
    logic [CFG_W-1:0]   m_pre_x, m_pre_y, m_post_x, m_post_y, m_weights;
    logic [KINDS_W-1:0] m_kinds;

    flame_point_transform dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .done(done),
        .out_x(out_x), .out_y(out_y), .range_flag(range_flag),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always #1 clk = ~clk;

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                   inout logic flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] affine(input logic [CFG_W-1:0] c,
                                                  input logic signed [63:0] x,
                                                  input logic signed [63:0] y,
                                                  inout logic flag);
        logic signed [63:0] a, b, o;
        a = 64'($signed(c[15:0]));
        b = 64'($signed(c[31:16]));
        o = 64'($signed(c[47:32]));
        return clamp32(((a * x + b * y) >>> 12) + (o <<< (FRAC - COEF_FB)), flag);
    endfunction

    function automatic logic signed [63:0] sine_q(input logic signed [63:0] v);
        logic signed [63:0] prod, r, z, z2, t;
        logic [15:0] ph;
        prod = v * 64'sd683565276;
        ph = prod[FRAC+31:FRAC+16];
        r = {50'b0, ph[13:0]};
        z = ph[14] ? 64'sd16384 - r : r;
        z2 = (z * z) >>> 14;
        t = ((64'sd1160 * z2) >>> 14) - 64'sd10512;
        t = ((t * z2) >>> 14) + 64'sd25736;
        t = (t * z) >>> 14;
        if (ph[15])
            t = -t;
        return t <<< (FRAC - 14);
    endfunction

    function automatic logic signed [63:0] invert_coord(input logic signed [63:0] c,
                                                        input logic [63:0] d,
                                                        inout logic flag);
        logic [63:0] mag, q;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        q = (mag << (2 * FRAC)) / d;
        if (c < 0)
        begin
            if (q > 64'd2147483648)
            begin
                flag = 1'b1;
                return -64'sd2147483648;
            end
            return -$signed(q);
        end
        return clamp32($signed(q > 64'd4294967296 ? 64'd4294967296 : q), flag);
    endfunction

    function automatic point_res_t transform_point(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
        point_res_t r;
        logic flag;
        logic signed [63:0] px, py, sx, sy, w, ax, ay, fx, fy;
        logic [63:0] d;
        logic [1:0] k;
        flag = 1'b0;
        ax = 0;
        ay = 0;
        px = affine(m_pre_x, 64'(x), 64'(y), flag);
        py = affine(m_pre_y, 64'(x), 64'(y), flag);
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            k = m_kinds[2*i +: 2];
            w = 64'($signed(m_weights[16*i +: 16]));
            sx = 0;
            sy = 0;
            case (kind_t'(k))
                KIND_ID:
                begin
                    sx = px;
                    sy = py;
                end
                KIND_SIN:
                begin
                    sx = sine_q(px);
                    sy = sine_q(py);
                end
                KIND_SPH:
                begin
                    d = 64'(px * px) + 64'(py * py);
                    if (d == 0)
                        flag = 1'b1;
                    else
                    begin
                        sx = invert_coord(px, d, flag);
                        sy = invert_coord(py, d, flag);
                    end
                end
                default: ;
            endcase
            ax += w * sx;
            ay += w * sy;
        end
        sx = clamp32(ax >>> 12, flag);
        sy = clamp32(ay >>> 12, flag);
        fx = affine(m_post_x, sx, sy, flag);
        fy = affine(m_post_y, sx, sy, flag);
        r.x = fx[31:0];
        r.y = fy[31:0];
        r.flag = flag;
        return r;
    endfunction

    task automatic apply_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        case (idx)
            REG_PRE_X:   m_pre_x = v;
            REG_PRE_Y:   m_pre_y = v;
            REG_POST_X:  m_post_x = v;
            REG_POST_Y:  m_post_y = v;
            REG_WEIGHTS: m_weights = v;
            REG_KINDS:   m_kinds = v[KINDS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report(input string msg);
        n_errors++;
        if (n_errors <= 30)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic add_point(input logic signed [31:0] x, input logic signed [31:0] y);
        jobs.push_back('{ACT_POINT, '0, '0, x, y});
    endtask

    task automatic add_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        jobs.push_back('{ACT_WRITE, idx, v, 0, 0});
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $signed($urandom());
            1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            2: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
            default: return $signed($urandom_range(0, 1 << 13)) - (1 << 12);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_coeffs();
        logic [CFG_W-1:0] c;
        if ($urandom_range(0, 3) == 0)
            return CFG_W'({$urandom(), $urandom()});
        for (int i = 0; i < 3; i++)
            c[16*i +: 16] = 16'($signed($urandom_range(0, 16'h3000)) - 16'sh1800);
        return c;
    endfunction

    // driver: bursts with random gaps; writes only once the pipeline has drained
    int burst_left = 0;
    int gap_left = 0;
    int quiet = 0;

    always @(posedge clk)
    begin
        job_t j;
        logic nstart;
        logic nwr;
        if (rst_n)
        begin
            if (wr_en)
            begin
                apply_write(wr_index, wr_data);
                n_writes++;
            end
            if (start && !busy)
            begin
                expected_pts.push_back(transform_point(point_x, point_y));
                n_points++;
            end
            nstart = start && busy;
            nwr = 1'b0;
            if (expected_pts.size() != 0 || start)
                quiet = 0;
            else
                quiet++;
            if (!nstart)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (jobs.size() != 0)
                begin
                    j = jobs[0];
                    case (j.act)
                        ACT_POINT:
                        begin
                            void'(jobs.pop_front());
                            nstart = 1'b1;
                            point_x <= j.x;
                            point_y <= j.y;
                            if (burst_left > 0)
                                burst_left--;
                            else
                            begin
                                burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                                  : $urandom_range(20, 60);
                                gap_left = $urandom_range(0, 2) == 0 ? 0
                                                                     : $urandom_range(1, 6);
                            end
                        end
                        ACT_DRAIN:
                            if (expected_pts.size() == 0 && !start)
                                void'(jobs.pop_front());
                        default:
                            if (quiet >= SETTLE)
                            begin
                                void'(jobs.pop_front());
                                nwr = 1'b1;
                                wr_index <= j.idx;
                                wr_data <= j.data;
                            end
                    endcase
                end
            end
            wr_en <= nwr;
            start <= nstart;
        end
    end

    // monitor: result words cannot be held off
    always @(posedge clk)
    begin
        point_res_t e;
        if (rst_n && done)
        begin
            if (expected_pts.size() == 0)
                report($sformatf("unexpected word x=%h y=%h", out_x, out_y));
            else
            begin
                e = expected_pts.pop_front();
                if (out_x !== e.x)
                    report($sformatf("out_x %h, want %h", out_x, e.x));
                if (out_y !== e.y)
                    report($sformatf("out_y %h, want %h", out_y, e.y));
                if (range_flag !== e.flag)
                    report($sformatf("range_flag %b, want %b", range_flag, e.flag));
                if (e.flag)
                    n_flagged++;
            end
        end
    end

    initial
    begin
        #400000;
        $display("flame_point_transform_tb: errors");
        $finish;
    end

    initial
    begin
        logic signed [31:0] edge_vals[5];
        logic [CFG_W-1:0] ones_q;
        m_pre_x = COEF_X_ONE;
        m_pre_y = COEF_Y_ONE;
        m_post_x = COEF_X_ONE;
        m_post_y = COEF_Y_ONE;
        m_weights = '0;
        m_kinds = '0;
        ones_q = {3{16'h1000}};
        edge_vals = '{32'sh0, 32'sh7FFFFFFF, -32'sh80000000, -32'sh1, 32'sh10000};

        // defaults: zero weights, so only the post offset shows
        for (int i = 0; i < 5; i++)
            add_point(edge_vals[i], edge_vals[4 - i]);

        // identity, sine and spherical at unit weight, zero radius first
        add_write(REG_WEIGHTS, ones_q);
        add_write(REG_KINDS, CFG_W'({KIND_SPH, KIND_SIN, KIND_ID}));
        add_point(0, 0);
        for (int i = 0; i < 5; i++)
            add_point(edge_vals[i], edge_vals[(i + 2) % 5]);
        add_point(32'sh3243F, -32'sh3243F);
        add_point(1, 0);
        add_point(32'sh100, 32'sh7FFFFFFF);

        // every slot off, plus an unused index that must be ignored
        jobs.push_back('{ACT_DRAIN, '0, '0, 0, 0});
        add_write(REG_KINDS, CFG_W'({KIND_OFF, KIND_OFF, KIND_OFF}));
        add_write(IDX_UNUSED, '1);
        add_point(32'sh12345678, -32'sh1234);
        add_point(-32'sh80000000, 32'sh7FFFFFFF);

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    for (int r = REG_PRE_X; r <= REG_KINDS; r++)
                        add_write(r[IDX_W-1:0], '0);
                end
                1:
                begin
                    for (int r = REG_PRE_X; r <= REG_KINDS; r++)
                        add_write(r[IDX_W-1:0], '1);
                end
                default:
                begin
                    add_write(REG_PRE_X, rand_coeffs());
                    add_write(REG_PRE_Y, rand_coeffs());
                    add_write(REG_POST_X, rand_coeffs());
                    add_write(REG_POST_Y, rand_coeffs());
                    add_write(REG_WEIGHTS, rand_coeffs());
                    add_write(REG_KINDS, CFG_W'($urandom_range(0, 63)));
                end
            endcase
            for (int i = 0; i < PER_PHASE; i++)
            begin
                add_point(rand_coord(), rand_coord());
                if (i == PER_PHASE / 2 && p % 3 == 0)
                    jobs.push_back('{ACT_DRAIN, '0, '0, 0, 0});
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (jobs.size() == 0 && !start && expected_pts.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (expected_pts.size() != 0)
            report($sformatf("%0d words never arrived", expected_pts.size()));

        $display("covered %0d points over %0d register writes, %0d results flagged",
                 n_points, n_writes, n_flagged);
        if (n_errors == 0)
            $display("flame_point_transform_tb: clean");
        else
            $display("flame_point_transform_tb: errors");
        $finish;
    end

endmodule
